>>> rtl/afm_pkg.sv
// ----------------------------------------------------------------------------
// afm_pkg
// Types, codes and reset constants shared by the adaptive frequency model.
// ----------------------------------------------------------------------------
package afm_pkg;

	localparam int MAX_SYMBOLS_DEF = 256;
	localparam int CFG_IW = 1;

	localparam logic [8:0]  RESET_SYMBOL_COUNT  = 9'd256;
	localparam logic [15:0] RESET_RESCALE_LIMIT = 16'd16383;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] REG_SYMBOL_COUNT  = 1'b0;
	localparam logic [CFG_IW-1:0] REG_RESCALE_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		CMD_ENCODE = 2'd0,
		CMD_DECODE = 2'd1,
		CMD_RESET  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  symbol;
		logic [15:0] slot;
	} item_t;

	typedef struct packed {
		logic [7:0]  found_symbol;
		logic [15:0] cum_low;
		logic [15:0] sym_freq;
		logic [15:0] total_count;
		logic        error;
	} result_t;

	typedef enum logic [1:0] {
		RES_HIT  = 2'd0,
		RES_ERR  = 2'd1,
		RES_ZERO = 2'd2
	} res_kind_t;

	typedef enum logic {
		TRS_IDX  = 1'b0,
		TRS_NEXT = 1'b1
	} tree_rsel_t;

	typedef enum logic [4:0] {
		S_FILL_START,
		S_RESC_START,
		S_SWEEP,
		S_IDLE,
		S_DISPATCH,
		S_ENC_RD,
		S_ENC_ACC,
		S_DEC_RD,
		S_DEC_CMP,
		S_FREQ_RD,
		S_FREQ_CAP,
		S_RESULT,
		S_ADD_RD,
		S_ADD_WR,
		S_CHECK,
		S_ERR_OUT,
		S_CLR_OUT
	} state_t;

	typedef struct packed {
		logic       item_load;
		logic       enc_init;
		logic       enc_step;
		logic       acc_add;
		logic       dec_init;
		logic       dec_skip;
		logic       dec_cmp;
		logic       dec_done;
		logic       freq_cap;
		logic       res_load;
		res_kind_t  res_kind;
		logic       bump;
		logic       add_wr;
		logic       sw_start;
		logic       sw_fill;
		logic       sw_run;
		logic       total_load;
		tree_rsel_t tree_rsel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] item_cmd;
		logic       sym_bad;
		logic       slot_bad;
		logic       idx_zero;
		logic       idx_over;
		logic       step_zero;
		logic       next_over;
		logic       pos_bad;
		logic       res_free;
		logic       sw_done;
		logic       total_hit;
		logic       sc_write;
		logic       cfg_busy;
	} dp_stat_t;

endpackage

>>> rtl/afm_ram.sv
// ----------------------------------------------------------------------------
// afm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module afm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/afm_dp.sv
// ----------------------------------------------------------------------------
// afm_dp
// Datapath: config registers, count and tree memories, walk registers,
// rebuild sweep and the result register.
// ----------------------------------------------------------------------------
module afm_dp #(
	parameter int MAX_SYMBOLS = afm_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [afm_pkg::CFG_IW-1:0] cfg_index,
	input  logic [15:0]               cfg_data,
	input  afm_pkg::item_t            in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output afm_pkg::result_t          out_item,
	input  afm_pkg::dp_cmd_t          cmd,
	output afm_pkg::dp_stat_t         stat
);

	import afm_pkg::*;

	localparam int CW = $clog2(MAX_SYMBOLS);
	localparam int TW = $clog2(MAX_SYMBOLS + 1);
	localparam int XW = TW + 1;
	localparam int KW = (TW > 8) ? TW : 8;
	localparam int NW = (TW > 9) ? TW : 9;
	localparam int FW = (CW > 8) ? CW : 8;
	localparam int LV = TW + 1;

	logic [8:0]    sc_q;
	logic [15:0]   limit_q;
	item_t         item_q;
	logic [CW-1:0] fsym_q;
	logic [XW-1:0] idx_q;
	logic [TW-1:0] pos_q;
	logic [TW-1:0] step_q;
	logic [15:0]   acc_q;
	logic [15:0]   freq_q;
	logic [15:0]   total_q;
	result_t       res_q;
	logic          out_valid_q;

	logic [TW-1:0] sw_idx_q;
	logic          sw_v_s1;
	logic [CW-1:0] sw_idx_s1;
	logic          sw_fill_q;
	logic [15:0]   psum_q;
	logic [15:0]   rec_q [LV];

	logic [TW-1:0] n;
	logic [TW-1:0] hp;
	logic [XW-1:0] next;
	logic [XW-1:0] idx_lb;
	logic [16:0]   dec_sum;
	logic [FW-1:0] fsym_w;

	logic [TW-1:0] sw_i;
	logic [TW-1:0] sw_lb;
	logic [LV-1:0] sw_mask;
	logic [15:0]   c_new;
	logic [15:0]   p_new;
	logic [15:0]   base;
	logic [15:0]   tree_w;

	logic          cnt_we;
	logic [CW-1:0] cnt_waddr;
	logic [15:0]   cnt_wdata;
	logic [CW-1:0] cnt_raddr;
	logic [15:0]   cnt_rdata;
	logic          tree_we;
	logic [TW-1:0] tree_waddr;
	logic [15:0]   tree_wdata;
	logic [TW-1:0] tree_raddr;
	logic [15:0]   tree_rdata;

	// live alphabet size: zero means one, saturate at the array size
	always_comb begin
		if (sc_q == '0) begin
			n = TW'(1);
		end else if (NW'(sc_q) > NW'(MAX_SYMBOLS)) begin
			n = TW'(MAX_SYMBOLS);
		end else begin
			n = TW'(sc_q);
		end
	end

	// top step of the decode descent
	always_comb begin
		hp = '0;
		for (int l = 0; l < TW; l++) begin
			if (n[l]) begin
				hp = TW'(1) << l;
			end
		end
	end

	assign next    = XW'(pos_q) + XW'(step_q);
	assign idx_lb  = idx_q & (~idx_q + XW'(1));
	assign dec_sum = 17'(acc_q) + 17'(tree_rdata);
	assign fsym_w  = FW'(fsym_q);

	// rebuild: tree[i] = prefix(i) - prefix(i - lowbit(i))
	assign sw_i  = TW'(sw_idx_s1) + TW'(1);
	assign sw_lb = sw_i & (~sw_i + TW'(1));
	assign c_new = sw_fill_q ? 16'd1 : ((cnt_rdata >> 1) | 16'd1);
	assign p_new = psum_q + c_new;

	always_comb begin
		base = '0;
		for (int l = 0; l < TW; l++) begin
			if (sw_lb[l]) begin
				base = rec_q[l + 1];
			end
		end
		for (int l = 0; l < LV; l++) begin
			sw_mask[l] = (sw_i & TW'((1 << l) - 1)) == '0;
		end
	end

	assign tree_w = p_new - base;

	// memory port steering
	always_comb begin
		cnt_raddr = cmd.sw_run ? sw_idx_q[CW-1:0] : fsym_q;
		cnt_we    = sw_v_s1 || cmd.bump;
		if (sw_v_s1) begin
			cnt_waddr = sw_idx_s1;
			cnt_wdata = c_new;
		end else begin
			cnt_waddr = fsym_q;
			cnt_wdata = freq_q + 16'd1;
		end
		tree_raddr = (cmd.tree_rsel == TRS_NEXT) ? next[TW-1:0] : idx_q[TW-1:0];
		tree_we    = sw_v_s1 || cmd.add_wr;
		if (sw_v_s1) begin
			tree_waddr = sw_i;
			tree_wdata = tree_w;
		end else begin
			tree_waddr = idx_q[TW-1:0];
			tree_wdata = tree_rdata + 16'd1;
		end
	end

	afm_ram #(.WIDTH(16), .DEPTH(MAX_SYMBOLS)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	afm_ram #(.WIDTH(16), .DEPTH(MAX_SYMBOLS + 1)) u_tree_ram (
		.clk   (clk),
		.we    (tree_we),
		.waddr (tree_waddr),
		.wdata (tree_wdata),
		.raddr (tree_raddr),
		.rdata (tree_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q        <= RESET_SYMBOL_COUNT;
			limit_q     <= RESET_RESCALE_LIMIT;
			out_valid_q <= 1'b0;
			sw_v_s1     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SYMBOL_COUNT: begin
						sc_q <= cfg_data[8:0];
					end
					REG_RESCALE_LIMIT: begin
						limit_q <= cfg_data;
					end
				endcase
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			sw_v_s1 <= cmd.sw_run && (sw_idx_q < n);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= in_item;
		end
		if (cmd.enc_init) begin
			fsym_q <= CW'(item_q.symbol);
			idx_q  <= XW'(item_q.symbol);
			acc_q  <= '0;
		end
		if (cmd.enc_step) begin
			idx_q <= idx_q & (idx_q - XW'(1));
		end
		if (cmd.acc_add) begin
			acc_q <= acc_q + tree_rdata;
		end
		if (cmd.dec_init) begin
			pos_q  <= '0;
			step_q <= hp;
			acc_q  <= '0;
		end
		if (cmd.dec_skip) begin
			step_q <= step_q >> 1;
		end
		if (cmd.dec_cmp) begin
			if (dec_sum <= 17'(item_q.slot)) begin
				pos_q <= next[TW-1:0];
				acc_q <= dec_sum[15:0];
			end
			step_q <= step_q >> 1;
		end
		if (cmd.dec_done) begin
			fsym_q <= pos_q[CW-1:0];
		end
		if (cmd.freq_cap) begin
			freq_q <= cnt_rdata;
		end
		if (cmd.res_load) begin
			unique case (cmd.res_kind)
				RES_HIT: begin
					res_q.found_symbol <= fsym_w[7:0];
					res_q.cum_low      <= acc_q;
					res_q.sym_freq     <= freq_q;
					res_q.total_count  <= total_q;
					res_q.error        <= 1'b0;
				end
				RES_ERR: begin
					res_q       <= '0;
					res_q.error <= 1'b1;
				end
				default: begin
					res_q <= '0;
				end
			endcase
		end
		if (cmd.bump) begin
			total_q <= total_q + 16'd1;
			idx_q   <= XW'(fsym_q) + XW'(1);
		end
		if (cmd.add_wr) begin
			idx_q <= idx_q + idx_lb;
		end
		if (cmd.total_load) begin
			total_q <= psum_q;
		end
		if (cmd.sw_start) begin
			sw_idx_q  <= '0;
			psum_q    <= '0;
			sw_fill_q <= cmd.sw_fill;
			for (int l = 0; l < LV; l++) begin
				rec_q[l] <= '0;
			end
		end else begin
			if (cmd.sw_run && (sw_idx_q < n)) begin
				sw_idx_q  <= sw_idx_q + TW'(1);
				sw_idx_s1 <= sw_idx_q[CW-1:0];
			end
			if (sw_v_s1) begin
				psum_q <= p_new;
				for (int l = 0; l < LV; l++) begin
					if (sw_mask[l]) begin
						rec_q[l] <= p_new;
					end
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = res_q;

	always_comb begin
		stat.item_cmd  = item_q.cmd;
		stat.sym_bad   = KW'(item_q.symbol) >= KW'(n);
		stat.slot_bad  = item_q.slot >= total_q;
		stat.idx_zero  = idx_q == '0;
		stat.idx_over  = idx_q > XW'(n);
		stat.step_zero = step_q == '0;
		stat.next_over = next > XW'(n);
		stat.pos_bad   = pos_q >= n;
		stat.res_free  = !out_valid_q || !out_stall;
		stat.sw_done   = (sw_idx_q == n) && !sw_v_s1;
		stat.total_hit = total_q >= limit_q;
		stat.sc_write  = cfg_valid && (cfg_index == REG_SYMBOL_COUNT);
		stat.cfg_busy  = cfg_valid;
	end

endmodule

>>> rtl/afm_ctrl.sv
// ----------------------------------------------------------------------------
// afm_ctrl
// Controller: sequences lookups, tree walks, result hand-off and rebuilds.
// ----------------------------------------------------------------------------
module afm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  afm_pkg::dp_stat_t  stat,
	output afm_pkg::dp_cmd_t   cmd
);

	import afm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = (state_q != S_IDLE) || stat.cfg_busy;
		unique case (state_q)
			S_FILL_START: begin
				cmd.sw_start = 1'b1;
				cmd.sw_fill  = 1'b1;
				state_d      = S_SWEEP;
			end
			S_RESC_START: begin
				cmd.sw_start = 1'b1;
				state_d      = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sw_run = 1'b1;
				if (stat.sw_done) begin
					cmd.total_load = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.item_load = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.item_cmd)
					CMD_ENCODE: begin
						if (stat.sym_bad) begin
							state_d = S_ERR_OUT;
						end else begin
							cmd.enc_init = 1'b1;
							state_d      = S_ENC_RD;
						end
					end
					CMD_DECODE: begin
						if (stat.slot_bad) begin
							state_d = S_ERR_OUT;
						end else begin
							cmd.dec_init = 1'b1;
							state_d      = S_DEC_RD;
						end
					end
					CMD_RESET: begin
						state_d = S_CLR_OUT;
					end
					default: begin
						state_d = S_ERR_OUT;
					end
				endcase
			end
			S_ENC_RD: begin
				if (stat.idx_zero) begin
					state_d = S_FREQ_RD;
				end else begin
					cmd.tree_rsel = TRS_IDX;
					cmd.enc_step  = 1'b1;
					state_d       = S_ENC_ACC;
				end
			end
			S_ENC_ACC: begin
				cmd.acc_add = 1'b1;
				state_d     = S_ENC_RD;
			end
			S_DEC_RD: begin
				priority if (stat.step_zero) begin
					if (stat.pos_bad) begin
						state_d = S_ERR_OUT;
					end else begin
						cmd.dec_done = 1'b1;
						state_d      = S_FREQ_RD;
					end
				end else if (stat.next_over) begin
					cmd.dec_skip = 1'b1;
				end else begin
					cmd.tree_rsel = TRS_NEXT;
					state_d       = S_DEC_CMP;
				end
			end
			S_DEC_CMP: begin
				cmd.tree_rsel = TRS_NEXT;
				cmd.dec_cmp   = 1'b1;
				state_d       = S_DEC_RD;
			end
			S_FREQ_RD: begin
				state_d = S_FREQ_CAP;
			end
			S_FREQ_CAP: begin
				cmd.freq_cap = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (stat.res_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_HIT;
					cmd.bump     = 1'b1;
					state_d      = S_ADD_RD;
				end
			end
			S_ADD_RD: begin
				if (stat.idx_over) begin
					state_d = S_CHECK;
				end else begin
					cmd.tree_rsel = TRS_IDX;
					state_d       = S_ADD_WR;
				end
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = S_ADD_RD;
			end
			S_CHECK: begin
				state_d = stat.total_hit ? S_RESC_START : S_IDLE;
			end
			S_ERR_OUT: begin
				if (stat.res_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ERR;
					state_d      = S_IDLE;
				end
			end
			S_CLR_OUT: begin
				if (stat.res_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ZERO;
					state_d      = S_FILL_START;
				end
			end
			default: begin
				state_d = S_FILL_START;
			end
		endcase
		// a new alphabet size restarts the fill
		if (stat.sc_write) begin
			state_d = S_FILL_START;
		end
	end

endmodule

>>> rtl/adaptive_frequency_model.sv
// ----------------------------------------------------------------------------
// adaptive_frequency_model
// Adaptive symbol-frequency model with a cumulative-count tree for entropy
// coding: encode by symbol, decode by slot, count reset.
// ----------------------------------------------------------------------------
// One item at a time. Each tree step is one read and one accumulate or
// write on the single-read-port tree memory; the count update touches at
// most log2(n) + 1 tree nodes, where n is the live alphabet size. When the
// total reaches rescale_limit, the halving pass streams all n counts
// through the count memory and rebuilds the tree. After reset, after a count
// reset command and after every write of symbol_count, a fill pass
// initializes the memories while in_stall is high; configuration writes
// are taken at any time (cfg_ready is always high).
module adaptive_frequency_model #(
	parameter int MAX_SYMBOLS = afm_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  afm_pkg::item_t             in_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output afm_pkg::result_t           out_item,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [afm_pkg::CFG_IW-1:0] cfg_index,
	input  logic [15:0]                cfg_data
);

	import afm_pkg::*;

	dp_cmd_t  ctl_cmd;
	dp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	afm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	afm_dp #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cmd       (ctl_cmd),
		.stat      (dp_stat)
	);

`ifndef NO_ASSERTIONS
	// no item taken while the memories are being rebuilt
	a_stall_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.sw_run |-> in_stall)
		else $error("item accepted during rebuild sweep");

	// a result is never loaded over one still waiting
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.res_load |-> dp_stat.res_free)
		else $error("result register overwritten");

	// a new alphabet size blocks input on the next cycle
	a_sc_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == REG_SYMBOL_COUNT)) |=> in_stall)
		else $error("input open right after symbol_count write");

	// output valid rises only from a result load
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl_cmd.res_load))
		else $error("output valid without result load");
`endif

endmodule
